// ===== src/sed_pkg.sv =====
// shared constants, types and helpers for the sobel edge detector
// no dependencies; imported by the top level, sed_ctrl and sed_dp
package sed_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int LINE_AW    = $clog2(MAX_WIDTH);
  localparam int CNT_W      = 9;
  localparam int ROW_W      = CNT_W + 1;
  localparam int PIX_W      = 24;
  localparam int GRAD_W     = 11;
  localparam int SQ_W       = 21;
  localparam int ROOT_STEPS = 8;
  localparam int STEP_W     = 3;
  localparam int LUMA_W     = 18;

  localparam logic [CNT_W-1:0] MIN_DIM    = CNT_W'(3);
  localparam logic [CNT_W-1:0] MAX_W_VAL  = CNT_W'(MAX_WIDTH);
  localparam logic [CNT_W-1:0] MAX_H_VAL  = CNT_W'(MAX_HEIGHT);
  localparam logic [LUMA_W-1:0] WHITE_THRESH = LUMA_W'(128000);
  localparam logic [9:0] COEF_R = 10'd299;
  localparam logic [9:0] COEF_G = 10'd587;
  localparam logic [9:0] COEF_B = 10'd114;
  localparam logic [SQ_W-1:0] SAT_LIMIT = SQ_W'(65536);

  // register map, index = paddr[3:2]
  localparam logic [1:0] REG_EDGE_MODE    = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

  typedef struct packed {
    logic              take;
    logic              load;
    logic              grad;
    logic              sq;
    logic              root_step;
    logic [STEP_W-1:0] root_bit;
    logic              out_load;
  } sed_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic emit;
    logic mode;
    logic out_free;
  } sed_stat_t;

  function automatic logic is_white(input logic [PIX_W-1:0] px);
    logic [LUMA_W-1:0] s;
    s = LUMA_W'(COEF_R) * LUMA_W'(px[23:16]) + LUMA_W'(COEF_G) * LUMA_W'(px[15:8])
      + LUMA_W'(COEF_B) * LUMA_W'(px[7:0]);
    return s >= WHITE_THRESH;
  endfunction

endpackage

// ===== src/sed_in_if.sv =====
// input word channel: valid/ready handshake with one rgb pixel or flush
// no dependencies
interface sed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic       flush;
  modport source(output valid, red_in, green_in, blue_in, flush, input ready);
  modport sink(input valid, red_in, green_in, blue_in, flush, output ready);
endinterface

// ===== src/sed_out_if.sv =====
// output word channel: valid/ready handshake with one edge result
// no dependencies
interface sed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       frame_last;
  modport source(output valid, red_out, green_out, blue_out, frame_last, input ready);
  modport sink(input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

// ===== src/sobel_edge_detector.sv =====
// top level of the streaming 3x3 sobel edge detector
// depends on sed_pkg, sed_in_if, sed_out_if, sed_ctrl, sed_dp
//
// usage:
//   in_word carries raster rgb pixels; flush marks padding words. after the
//   last pixel of a frame, frame_width+1 more words (normally flush) drain
//   the tail. each word n >= W+1 of a frame yields the result for pixel
//   n-W-1 on out_word; frame_last marks the frame's final pixel.
//   configuration goes through the apb port: 0x0 edge_mode, 0x4 frame_width,
//   0x8 frame_height; write only while the block is idle.
// sequencing:
//   one word is worked at a time by the controller. a word that yields no
//   result passes the take and load states; a binary-mode result also the
//   gradient and output states; a gradient result also the square state and
//   the 8-step square root (one result bit a cycle, three channels side by
//   side) before output. the output register is loaded once it is free.
// reset and stall:
//   rst (synchronous) clears counters, window and output valid, and loads
//   edge_mode=1, 256x256. a stalled receiver holds the output word; the
//   next word is still accepted and worked up to its result, which waits.
module sobel_edge_detector (
  input  logic             clk,
  input  logic             rst,
  sed_in_if.sink           in_word,
  sed_out_if.source        out_word,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import sed_pkg::*;

  logic             edge_mode;
  logic [CNT_W-1:0] frame_width;
  logic [CNT_W-1:0] frame_height;
  logic             cfg_wr;
  sed_cmd_t         cmd;
  sed_stat_t        stat;
  logic             in_ready;

  // apb register write on the access phase
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_mode    <= 1'b1;
      frame_width  <= MAX_W_VAL;
      frame_height <= MAX_H_VAL;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_EDGE_MODE:    edge_mode    <= pwdata[0];
        REG_FRAME_WIDTH:  frame_width  <= pwdata[CNT_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      REG_EDGE_MODE:    prdata = {31'd0, edge_mode};
      REG_FRAME_WIDTH:  prdata = {{(32-CNT_W){1'b0}}, frame_width};
      REG_FRAME_HEIGHT: prdata = {{(32-CNT_W){1'b0}}, frame_height};
      default:          prdata = '0;
    endcase
  end

  assign in_word.ready = in_ready;

  // sequencing
  sed_ctrl u_ctrl (
    .clk(clk), .rst(rst), .stat(stat), .cmd(cmd), .in_ready(in_ready)
  );

  // line stores, window, arithmetic and output register
  sed_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_valid(in_word.valid),
    .red_in(in_word.red_in), .green_in(in_word.green_in),
    .blue_in(in_word.blue_in), .flush(in_word.flush),
    .edge_mode(edge_mode), .frame_width(frame_width), .frame_height(frame_height),
    .out_valid(out_word.valid), .out_ready(out_word.ready),
    .red_out(out_word.red_out), .green_out(out_word.green_out),
    .blue_out(out_word.blue_out), .frame_last(out_word.frame_last)
  );
endmodule

// ===== src/sed_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module sed_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/sed_ctrl.sv =====
// controller state machine sequencing one word through the datapath
// depends on sed_pkg
module sed_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  sed_pkg::sed_stat_t stat,
  output sed_pkg::sed_cmd_t  cmd,
  output logic              in_ready
);
  import sed_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_GRAD = 3'd2;
  localparam logic [2:0] S_SQ   = 3'd3;
  localparam logic [2:0] S_ROOT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]        state, state_next;
  logic [STEP_W-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    cmd.root_bit = STEP_W'(ROOT_STEPS - 1) - step;
    case (state)
      S_IDLE: begin
        if (stat.in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = stat.emit ? S_GRAD : S_IDLE;
      end
      S_GRAD: begin
        cmd.grad   = 1'b1;
        state_next = stat.mode ? S_SQ : S_OUT;
      end
      S_SQ: begin
        cmd.sq     = 1'b1;
        step_next  = '0;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        step_next     = step + STEP_W'(1);
        if (step == STEP_W'(ROOT_STEPS - 1)) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

`ifndef ASSERT_OFF
  a_take_load: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> state == S_LOAD) else $error("take not followed by load");
  a_root_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT && step == STEP_W'(ROOT_STEPS - 1)) |=> state == S_OUT)
    else $error("root iteration overran");
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free) else $error("result loaded over held word");
`endif
endmodule

// ===== src/sed_dp.sv =====
// datapath: counters, line stores, 3x3 window, gradient, root, output register
// depends on sed_pkg and sed_ram
module sed_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  sed_pkg::sed_cmd_t         cmd,
  output sed_pkg::sed_stat_t        stat,
  input  logic                     in_valid,
  input  logic [7:0]               red_in,
  input  logic [7:0]               green_in,
  input  logic [7:0]               blue_in,
  input  logic                     flush,
  input  logic                     edge_mode,
  input  logic [sed_pkg::CNT_W-1:0] frame_width,
  input  logic [sed_pkg::CNT_W-1:0] frame_height,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               red_out,
  output logic [7:0]               green_out,
  output logic [7:0]               blue_out,
  output logic                     frame_last
);
  import sed_pkg::*;

  logic [CNT_W-1:0] column_count, column_count_next;
  logic [CNT_W-1:0] row_count, row_count_next;
  logic [CNT_W-1:0] w, h;
  logic [CNT_W-1:0] col1;
  logic [ROW_W-1:0] row1;
  logic [CNT_W-1:0] ri;
  logic [LINE_AW-1:0] ci_c;
  logic [CNT_W-1:0] cr_c, cc_c;
  logic emit_c, last_c;

  logic [PIX_W-1:0]   px;
  logic [LINE_AW-1:0] ci;
  logic [CNT_W-1:0]   cr, cc, wm1, hm1;
  logic emit, last;

  logic [PIX_W-1:0] up_rd, mid_rd;
  logic [PIX_W-1:0] win [3][3];
  logic [PIX_W-1:0] nb [3][3];

  logic signed [GRAD_W-1:0] gx [3], gy [3];
  logic [SQ_W-1:0] sq [3];
  logic [7:0]      root [3];
  logic            bin_same;

  // position normalization and result bookkeeping for the arriving word
  always_comb begin
    w = frame_width;
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > MAX_W_VAL) w = MAX_W_VAL;
    h = frame_height;
    if (h < MIN_DIM) h = MIN_DIM;
    if (h > MAX_H_VAL) h = MAX_H_VAL;
    col1 = column_count;
    row1 = {1'b0, row_count};
    if (column_count >= w) begin
      col1 = '0;
      row1 = row1 + ROW_W'(1);
    end
    if (row1 > ({1'b0, h} + ROW_W'(1)) ||
        (row1 == ({1'b0, h} + ROW_W'(1)) && col1 != '0)) begin
      row1 = '0;
      col1 = '0;
    end
    ri   = row1[CNT_W-1:0];
    ci_c = col1[LINE_AW-1:0];
    emit_c = (ri >= CNT_W'(2)) || (ri == CNT_W'(1) && col1 >= CNT_W'(1));
    if (col1 >= CNT_W'(1)) begin
      cr_c = ri - CNT_W'(1);
      cc_c = col1 - CNT_W'(1);
    end else begin
      cr_c = ri - CNT_W'(2);
      cc_c = w - CNT_W'(1);
    end
    last_c = emit_c && cr_c == h - CNT_W'(1) && cc_c == w - CNT_W'(1);
    if (last_c) begin
      column_count_next = '0;
      row_count_next    = '0;
    end else begin
      column_count_next = col1 + CNT_W'(1);
      row_count_next    = ri;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      emit         <= 1'b0;
    end else if (cmd.take) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      emit         <= emit_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      px   <= flush ? '0 : {red_in, green_in, blue_in};
      ci   <= ci_c;
      cr   <= cr_c;
      cc   <= cc_c;
      last <= last_c;
      wm1  <= w - CNT_W'(1);
      hm1  <= h - CNT_W'(1);
    end
  end

  sed_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk(clk), .we(cmd.load), .waddr(ci), .wdata(mid_rd), .raddr(ci_c), .rdata(up_rd)
  );
  sed_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk(clk), .we(cmd.load), .waddr(ci), .wdata(px), .raddr(ci_c), .rdata(mid_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (cmd.load) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= up_rd;
      win[1][2] <= mid_rd;
      win[2][2] <= px;
    end
  end

  // out-of-frame taps read as black
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r == 0 && cr == '0) || (r == 2 && cr == hm1) ||
            (c == 0 && cc == '0) || (c == 2 && cc == wm1)) begin
          nb[r][c] = '0;
        end else begin
          nb[r][c] = win[r][c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.grad) begin
      for (int k = 0; k < 3; k++) begin
        gx[k] <= $signed({1'b0, 10'(nb[0][2][23-8*k -: 8]) + 10'({nb[1][2][23-8*k -: 8], 1'b0})
                   + 10'(nb[2][2][23-8*k -: 8])})
               - $signed({1'b0, 10'(nb[0][0][23-8*k -: 8]) + 10'({nb[1][0][23-8*k -: 8], 1'b0})
                   + 10'(nb[2][0][23-8*k -: 8])});
        gy[k] <= $signed({1'b0, 10'(nb[0][0][23-8*k -: 8]) + 10'({nb[0][1][23-8*k -: 8], 1'b0})
                   + 10'(nb[0][2][23-8*k -: 8])})
               - $signed({1'b0, 10'(nb[2][0][23-8*k -: 8]) + 10'({nb[2][1][23-8*k -: 8], 1'b0})
                   + 10'(nb[2][2][23-8*k -: 8])});
      end
      bin_same <= (is_white(nb[0][1]) == is_white(nb[1][1])) &&
                  (is_white(nb[2][1]) == is_white(nb[1][1])) &&
                  (is_white(nb[1][0]) == is_white(nb[1][1])) &&
                  (is_white(nb[1][2]) == is_white(nb[1][1]));
    end
  end

  // squares then one result bit per step
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd.sq) begin
        sq[k]   <= SQ_W'($unsigned(SQ_W'(gx[k]) * SQ_W'(gx[k])))
                 + SQ_W'($unsigned(SQ_W'(gy[k]) * SQ_W'(gy[k])));
        root[k] <= '0;
      end else if (cmd.root_step) begin
        if (16'(root[k] | (8'd1 << cmd.root_bit)) * 16'(root[k] | (8'd1 << cmd.root_bit))
            <= sq[k]) begin
          root[k] <= root[k] | (8'd1 << cmd.root_bit);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (edge_mode) begin
        red_out   <= (sq[0] >= SAT_LIMIT) ? 8'hFF : root[0];
        green_out <= (sq[1] >= SAT_LIMIT) ? 8'hFF : root[1];
        blue_out  <= (sq[2] >= SAT_LIMIT) ? 8'hFF : root[2];
      end else begin
        red_out   <= bin_same ? 8'hFF : 8'h00;
        green_out <= bin_same ? 8'hFF : 8'h00;
        blue_out  <= bin_same ? 8'hFF : 8'h00;
      end
      frame_last <= last;
    end
  end

  assign stat.in_valid = in_valid;
  assign stat.emit     = emit;
  assign stat.mode     = edge_mode;
  assign stat.out_free = !out_valid || out_ready;

`ifndef ASSERT_OFF
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    column_count <= MAX_W_VAL) else $error("column count out of range");
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && last_c) |=> (column_count == '0 && row_count == '0))
    else $error("counters not cleared after frame end");
  a_last_emit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_last) |-> !($past(cmd.take) && $past(!emit_c) && $past(last_c)))
    else $error("frame end without result");
`endif
endmodule
